[rtl/lcdser_pkg.sv]
// Shared types, constants and the init nibble table for the LCD nibble serialiser.
package lcdser_pkg;

  localparam int COLUMNS_DEFAULT = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_BEGIN = 3'd1;
  localparam logic [2:0] OP_TEXT = 3'd2;
  localparam logic [2:0] OP_ROW = 3'd3;
  localparam logic [2:0] OP_CURSOR_ON = 3'd4;
  localparam logic [2:0] OP_CURSOR_OFF = 3'd5;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_ROW1 = 8'h80;
  localparam logic [7:0] CMD_ROW2 = 8'hC0;
  localparam logic [7:0] CMD_CURSOR_ON = 8'h0F;
  localparam logic [7:0] CMD_CURSOR_OFF = 8'h0C;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_END = 8'd0;

  localparam logic [3:0] INIT_LAST = 4'd14;
  localparam logic [3:0] ONE_MSG_LAST = 4'd1;
  localparam logic [3:0] TWO_MSG_LAST = 4'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_code;
    logic       row_select;
  } item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       is_init;
    logic       two_msgs;
    logic [7:0] msg0;
    logic       rs0;
    logic [7:0] msg1;
  } job_t;

  // Three wake-up nibbles followed by the six set-up commands, high nibble first.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0: nib = 4'h3;
      4'd1: nib = 4'h3;
      4'd2: nib = 4'h2;
      4'd3: nib = 4'h2;
      4'd4: nib = 4'h8;
      4'd5: nib = 4'h0;
      4'd6: nib = 4'h8;
      4'd7: nib = 4'h0;
      4'd8: nib = 4'h2;
      4'd9: nib = 4'h0;
      4'd10: nib = 4'h6;
      4'd11: nib = 4'h0;
      4'd12: nib = 4'hC;
      4'd13: nib = 4'h0;
      4'd14: nib = 4'h1;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

[rtl/lcdser_front.sv]
// Front end: classifies each request, keeps the text layout state and builds jobs.
module lcdser_front #(
  parameter int COLUMNS = lcdser_pkg::COLUMNS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  lcdser_pkg::item_t  req,
  output logic               push,
  output lcdser_pkg::job_t   job
);

  logic [6:0] char_position;
  logic [6:0] char_position_next;
  logic       text_stopped;
  logic       text_stopped_next;
  logic [6:0] pos_inc;
  logic       has_job;

  assign pos_inc = char_position + 7'd1;

  always_comb begin
    has_job = 1'b0;
    job = '0;
    char_position_next = char_position;
    text_stopped_next = text_stopped;
    unique case (req.operation)
      lcdser_pkg::OP_INIT: begin
        has_job = 1'b1;
        job.is_init = 1'b1;
      end
      lcdser_pkg::OP_BEGIN: begin
        has_job = 1'b1;
        job.two_msgs = 1'b1;
        job.msg0 = lcdser_pkg::CMD_CLEAR;
        job.msg1 = lcdser_pkg::CMD_ROW1;
        char_position_next = 7'd0;
        text_stopped_next = 1'b0;
      end
      lcdser_pkg::OP_TEXT: begin
        if (!text_stopped) begin
          priority if (req.char_code == lcdser_pkg::CHAR_NEWLINE) begin
            has_job = 1'b1;
            job.msg0 = lcdser_pkg::CMD_ROW2;
            char_position_next = 7'd0;
          end else if (req.char_code == lcdser_pkg::CHAR_END) begin
            text_stopped_next = 1'b1;
          end else begin
            has_job = 1'b1;
            job.msg0 = req.char_code;
            job.rs0 = 1'b1;
            char_position_next = pos_inc;
            if (pos_inc == 7'(COLUMNS)) begin
              job.two_msgs = 1'b1;
              job.msg1 = lcdser_pkg::CMD_ROW2;
            end else if (pos_inc >= 7'(2 * COLUMNS)) begin
              text_stopped_next = 1'b1;
            end
          end
        end
      end
      lcdser_pkg::OP_ROW: begin
        has_job = 1'b1;
        job.msg0 = req.row_select ? lcdser_pkg::CMD_ROW2 : lcdser_pkg::CMD_ROW1;
      end
      lcdser_pkg::OP_CURSOR_ON: begin
        has_job = 1'b1;
        job.msg0 = lcdser_pkg::CMD_CURSOR_ON;
      end
      lcdser_pkg::OP_CURSOR_OFF: begin
        has_job = 1'b1;
        job.msg0 = lcdser_pkg::CMD_CURSOR_OFF;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  assign push = accept && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= 7'd0;
      text_stopped <= 1'b0;
    end else if (accept) begin
      char_position <= char_position_next;
      text_stopped <= text_stopped_next;
    end
  end

endmodule

[rtl/lcdser_queue.sv]
// Short job queue between the front end and the byte sequencer.
module lcdser_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lcdser_pkg::job_t  push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output lcdser_pkg::job_t  head_job
);

  lcdser_pkg::job_t                 store [lcdser_pkg::QDEPTH];
  logic [lcdser_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lcdser_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lcdser_pkg::QPTR_W:0]      count;

  assign full = (count == (lcdser_pkg::QPTR_W + 1)'(lcdser_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head_job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lcdser_back.sv]
// Back end: steps through the nibbles of each job and drives the output register.
module lcdser_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                q_not_empty,
  input  lcdser_pkg::job_t    q_job,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lcdser_pkg::result_t rsp
);

  lcdser_pkg::job_t cur;
  logic             active;
  logic [3:0]       nib_idx;
  logic             phase;
  logic             backlight_on;
  logic             advance;
  logic             finishing;
  logic [3:0]       last_idx;
  logic [3:0]       nib;
  logic             rs;
  logic [7:0]       out_byte;

  assign advance = !rsp_valid || !rsp_stall;

  always_comb begin
    priority if (cur.is_init) begin
      last_idx = lcdser_pkg::INIT_LAST;
    end else if (cur.two_msgs) begin
      last_idx = lcdser_pkg::TWO_MSG_LAST;
    end else begin
      last_idx = lcdser_pkg::ONE_MSG_LAST;
    end
  end

  always_comb begin
    if (cur.is_init) begin
      nib = lcdser_pkg::init_nibble(nib_idx);
      rs = 1'b0;
    end else begin
      unique case (nib_idx[1:0])
        2'd0: nib = cur.msg0[7:4];
        2'd1: nib = cur.msg0[3:0];
        2'd2: nib = cur.msg1[7:4];
        2'd3: nib = cur.msg1[3:0];
        default: nib = 4'h0;
      endcase
      rs = (nib_idx[1] == 1'b0) ? cur.rs0 : 1'b0;
    end
  end

  assign out_byte = {nib, backlight_on, !phase, 1'b0, rs};
  assign finishing = active && phase && (nib_idx == last_idx);
  assign pop = advance && (!active || finishing) && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_valid) begin
      backlight_on <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (advance && active) begin
      rsp.expander_byte <= out_byte;
      rsp.last <= finishing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      nib_idx <= 4'd0;
      phase <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= active;
      if (pop) begin
        active <= 1'b1;
        nib_idx <= 4'd0;
        phase <= 1'b0;
      end else if (finishing) begin
        active <= 1'b0;
      end else if (active) begin
        phase <= !phase;
        if (phase) begin
          nib_idx <= nib_idx + 4'd1;
        end
      end
    end
  end

endmodule

[rtl/lcd_text_nibble_serializer.sv]
// Top level of the LCD text nibble serialiser for a 4-bit expander-driven display.
//
//  Channel  Signals                        Direction  Moves
//  req      req_valid, req_stall, req      in         one display operation per request
//  rsp      rsp_valid, rsp_stall, rsp      out        one expander byte per transfer
//  cfg      cfg_valid, cfg_ready, cfg_data in         backlight bit, always ready
//
// Each LCD message is sent as four expander bytes and init as thirty; the byte
// sequencer emits one byte per cycle while rsp_stall is low, and loads a job first when it starts from empty.
// Requests are taken while the four-entry job queue has room, so the front end
// keeps accepting while earlier bytes still wait on a stalled output.
// Synchronous reset clears the layout state, the queue and the sequencer and sets
// the backlight bit.
module lcd_text_nibble_serializer #(
  parameter int COLUMNS = lcdser_pkg::COLUMNS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lcdser_pkg::item_t   req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lcdser_pkg::result_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             not_empty;
  lcdser_pkg::job_t push_job;
  lcdser_pkg::job_t head_job;

  assign req_stall = full;
  assign accept = req_valid && !full;
  assign cfg_ready = 1'b1;

  lcdser_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .push   (push),
    .job    (push_job)
  );

  lcdser_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  lcdser_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .q_not_empty (not_empty),
    .q_job       (head_job),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the LCD text nibble serialiser, with its own byte predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = lcdser_pkg::COLUMNS_DEFAULT;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
  localparam logic [7:0] CMD_HOME = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON = lcdser_pkg::CMD_CURSOR_OFF;

  localparam logic RS_CMD = 1'b0;
  localparam logic RS_DATA = 1'b1;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  lcdser_pkg::item_t   req;
  logic                rsp_valid;
  logic                rsp_stall;
  lcdser_pkg::result_t rsp;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  // Predictor state: a mirror of the layout state and the backlight register.
  logic [6:0] text_column;
  logic       text_halted;
  logic       backlight_bit;

  lcdser_pkg::result_t expected_bytes[$];
  lcdser_pkg::result_t wanted_byte;
  int                  error_count;
  int                  cycle_count;
  bit                  sender_idles;
  bit                  receiver_stalls;

  lcd_text_nibble_serializer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_nibble(input logic [3:0] nib, input logic rs);
    lcdser_pkg::result_t b;
    b.expander_byte = {nib, backlight_bit, 1'b1, 1'b0, rs};
    b.last = 1'b0;
    expected_bytes.push_back(b);
    b.expander_byte = {nib, backlight_bit, 1'b0, 1'b0, rs};
    expected_bytes.push_back(b);
  endfunction

  function automatic void push_message(input logic [7:0] msg, input logic rs);
    push_nibble(msg[7:4], rs);
    push_nibble(msg[3:0], rs);
  endfunction

  function automatic void predict_bytes(input lcdser_pkg::item_t it);
    int                  queued;
    lcdser_pkg::result_t tail;
    queued = expected_bytes.size();
    case (it.operation)
      lcdser_pkg::OP_INIT: begin
        push_nibble(NIB_WAKE, RS_CMD);
        push_nibble(NIB_WAKE, RS_CMD);
        push_nibble(NIB_FOUR_BIT, RS_CMD);
        push_message(CMD_FUNCTION_SET, RS_CMD);
        push_message(CMD_DISPLAY_OFF, RS_CMD);
        push_message(CMD_HOME, RS_CMD);
        push_message(CMD_ENTRY_MODE, RS_CMD);
        push_message(CMD_DISPLAY_ON, RS_CMD);
        push_message(lcdser_pkg::CMD_CLEAR, RS_CMD);
      end
      lcdser_pkg::OP_BEGIN: begin
        push_message(lcdser_pkg::CMD_CLEAR, RS_CMD);
        push_message(lcdser_pkg::CMD_ROW1, RS_CMD);
        text_column = '0;
        text_halted = 1'b0;
      end
      lcdser_pkg::OP_TEXT: begin
        if (!text_halted) begin
          if (it.char_code == lcdser_pkg::CHAR_NEWLINE) begin
            push_message(lcdser_pkg::CMD_ROW2, RS_CMD);
            text_column = '0;
          end else if (it.char_code == lcdser_pkg::CHAR_END) begin
            text_halted = 1'b1;
          end else begin
            push_message(it.char_code, RS_DATA);
            text_column = text_column + 7'd1;
            if (text_column == COLS) begin
              push_message(lcdser_pkg::CMD_ROW2, RS_CMD);
            end else if (text_column >= 2 * COLS) begin
              text_halted = 1'b1;
            end
          end
        end
      end
      lcdser_pkg::OP_ROW: begin
        push_message(it.row_select ? lcdser_pkg::CMD_ROW2 : lcdser_pkg::CMD_ROW1, RS_CMD);
      end
      lcdser_pkg::OP_CURSOR_ON: begin
        push_message(lcdser_pkg::CMD_CURSOR_ON, RS_CMD);
      end
      lcdser_pkg::OP_CURSOR_OFF: begin
        push_message(lcdser_pkg::CMD_CURSOR_OFF, RS_CMD);
      end
      default: begin
      end
    endcase
    if (expected_bytes.size() > queued) begin
      tail = expected_bytes[expected_bytes.size() - 1];
      tail.last = 1'b1;
      expected_bytes[expected_bytes.size() - 1] = tail;
    end
  endfunction

  function automatic lcdser_pkg::item_t make_item(input logic [2:0] op, input logic [7:0] ch,
                                                  input logic row);
    lcdser_pkg::item_t it;
    it.operation = op;
    it.char_code = ch;
    it.row_select = row;
    return it;
  endfunction

  function automatic int idle_length(input bit enabled);
    int pick;
    pick = $urandom_range(0, 99);
    if (!enabled || pick < 55) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] random_text_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      return lcdser_pkg::CHAR_NEWLINE;
    end
    if (pick < 8) begin
      return lcdser_pkg::CHAR_END;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_item(input lcdser_pkg::item_t it);
    int gap;
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_bytes(it);
    gap = idle_length(sender_idles);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_backlight(input logic value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    backlight_bit = value;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_power_up();
    send_item(make_item(lcdser_pkg::OP_INIT, 8'h00, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, "A", 1'b0));
    wait_idle();
  endtask

  task automatic test_operations();
    write_backlight(1'b0);
    send_item(make_item(lcdser_pkg::OP_BEGIN, 8'hFF, 1'b1));
    send_item(make_item(lcdser_pkg::OP_TEXT, 8'hFF, 1'b1));
    send_item(make_item(lcdser_pkg::OP_TEXT, 8'h01, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, lcdser_pkg::CHAR_NEWLINE, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, 8'h7E, 1'b1));
    send_item(make_item(lcdser_pkg::OP_ROW, 8'h00, 1'b0));
    send_item(make_item(lcdser_pkg::OP_ROW, 8'hFF, 1'b1));
    send_item(make_item(lcdser_pkg::OP_CURSOR_ON, 8'h55, 1'b0));
    send_item(make_item(lcdser_pkg::OP_CURSOR_OFF, 8'hAA, 1'b1));
    send_item(make_item(OP_SPARE_A, 8'h41, 1'b1));
    send_item(make_item(OP_SPARE_B, 8'hFF, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, lcdser_pkg::CHAR_END, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, "B", 1'b1));
    send_item(make_item(lcdser_pkg::OP_INIT, 8'hFF, 1'b1));
    send_item(make_item(lcdser_pkg::OP_BEGIN, 8'h00, 1'b0));
    send_item(make_item(lcdser_pkg::OP_TEXT, 8'h80, 1'b0));
    wait_idle();
  endtask

  // Mostly well-formed text runs after a begin, long enough to wrap and to stop,
  // mixed with commands, stray text and unused operations.
  task automatic test_random_layout(input int count, input logic backlight,
                                    input bit idles, input bit stalls);
    int sent;
    int pick;
    int run;
    write_backlight(backlight);
    sender_idles = idles;
    receiver_stalls = stalls;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(2 * COLS - 2, 2 * COLS + 6)
                                          : $urandom_range(1, COLS + 4);
        send_item(make_item(lcdser_pkg::OP_BEGIN, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
        repeat (run) begin
          send_item(make_item(lcdser_pkg::OP_TEXT, random_text_char(),
                              1'($urandom_range(0, 1))));
        end
        sent += run + 1;
      end else if (pick < 75) begin
        send_item(make_item(3'($urandom_range(lcdser_pkg::OP_INIT, lcdser_pkg::OP_CURSOR_OFF)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 93) begin
        send_item(make_item(lcdser_pkg::OP_TEXT, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_item(make_item(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B,
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    int stall_len;
    rsp_stall <= 1'b0;
    forever begin
      if (!receiver_stalls) begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        stall_len = idle_length(1'b1);
        if (stall_len > 0) begin
          rsp_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: expander_byte %02h last %0b", rsp.expander_byte, rsp.last);
        error_count++;
      end else begin
        wanted_byte = expected_bytes.pop_front();
        if (rsp.expander_byte !== wanted_byte.expander_byte) begin
          $error("expander_byte: expected %02h, actual %02h",
                 wanted_byte.expander_byte, rsp.expander_byte);
          error_count++;
        end
        if (rsp.last !== wanted_byte.last) begin
          $error("last: expected %0b, actual %0b", wanted_byte.last, rsp.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lcd_text_nibble_serializer: FAILED **");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    text_column = '0;
    text_halted = 1'b0;
    backlight_bit = 1'b1;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_up();
    test_operations();
    test_random_layout(60, 1'b1, 1'b1, 1'b1);
    test_random_layout(40, 1'b0, 1'b0, 1'b0);
    test_random_layout(60, 1'b0, 1'b1, 1'b1);
    test_random_layout(40, 1'b1, 1'b1, 1'b0);

    if (error_count == 0) begin
      $display("** lcd_text_nibble_serializer: PASSED **");
    end else begin
      $display("** lcd_text_nibble_serializer: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lcdser_pkg.sv
rtl/lcdser_front.sv
rtl/lcdser_queue.sv
rtl/lcdser_back.sv
rtl/lcd_text_nibble_serializer.sv
verif/testbench.sv
